// ----- rtl/core/tmpb_pkg.sv -----
// Shared types and constants for the tile mean-preserving binarizer.
package tmpb_pkg;

    localparam int unsigned BinW = 17;
    localparam int unsigned SumW = 24;
    localparam int unsigned LvlW = 10;
    localparam logic [BinW-1:0] BinMax = {BinW{1'b1}};
    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
    localparam logic [7:0] White = 8'd255;

    typedef enum logic {
        OP_GATHER = 1'b0,
        OP_APPLY  = 1'b1
    } t_op;

    typedef enum logic {
        KIND_LEVELS = 1'b0,
        KIND_PIXEL  = 1'b1
    } t_kind;

    // Request handed from the front part to the back part.
    typedef struct packed {
        t_op        op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_WALK,
        ST_FOLD,
        ST_CLEAR,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/core/tmpb_front.sv -----
// Front part: accept input requests into a short queue.
module tmpb_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tmpb_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output tmpb_pkg::t_req  o_req
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tmpb_pkg::t_req r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_req = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- rtl/core/tmpb_back.sv -----
// Back part: histogram update, bin walk, clearing and result register.
module tmpb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_offset,
    input  logic            i_valid,
    output logic            o_ready,
    input  tmpb_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [59:0]     o_data
);
    localparam int unsigned AccW = tmpb_pkg::SumW + 2;

    logic [tmpb_pkg::BinW-1:0] r_hist [3][256];
    logic [tmpb_pkg::BinW-1:0] r_rd [3];
    logic [tmpb_pkg::SumW-1:0] r_sum [3];
    logic [tmpb_pkg::LvlW-1:0] r_lvl [3];
    logic [AccW-1:0] r_acc [3], r_short [3];
    logic [7:0] r_stop [3];
    logic [2:0] r_run;
    tmpb_pkg::t_state r_state, n_state;
    tmpb_pkg::t_req r_req;
    logic [7:0] r_addr;
    logic [7:0] r_rd_addr;
    logic r_rd_vld;
    logic r_busy_out;
    logic [59:0] r_out;
    logic [7:0] pix [3];
    logic [AccW-1:0] walk_sum [3];
    logic [AccW-1:0] walk_add [3];
    logic [8:0] stop_lvl [3];

    assign pix[0] = r_req.red;
    assign pix[1] = r_req.green;
    assign pix[2] = r_req.blue;
    assign o_ready = (r_state == tmpb_pkg::ST_IDLE) && (!r_busy_out || i_ready);
    assign o_valid = r_busy_out;
    assign o_data = r_out;

    // Bin weight, channel target and final level with the step-back folded in.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            walk_sum[c] = AccW'(r_sum[c]);
            walk_add[c] = (AccW'(r_rd[c]) << 8) - AccW'(r_rd[c]);
            stop_lvl[c] = {1'b0, r_stop[c]};
            if (r_run[c] && r_acc[c] > walk_sum[c] &&
                (r_acc[c] - walk_sum[c]) > r_short[c]) begin
                stop_lvl[c] = stop_lvl[c] + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmpb_pkg::ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = (i_req.op == tmpb_pkg::OP_APPLY) ? tmpb_pkg::ST_EMIT
                                                               : tmpb_pkg::ST_READ;
                end
            end
            tmpb_pkg::ST_READ:  n_state = tmpb_pkg::ST_WRITE;
            tmpb_pkg::ST_WRITE: n_state = r_req.last ? tmpb_pkg::ST_WALK : tmpb_pkg::ST_IDLE;
            tmpb_pkg::ST_WALK:  n_state = (r_addr == 8'd0) ? tmpb_pkg::ST_FOLD
                                                           : tmpb_pkg::ST_WALK;
            tmpb_pkg::ST_FOLD:  n_state = tmpb_pkg::ST_EMIT;
            tmpb_pkg::ST_EMIT:  n_state = (r_req.op == tmpb_pkg::OP_GATHER) ? tmpb_pkg::ST_CLEAR
                                                                            : tmpb_pkg::ST_IDLE;
            tmpb_pkg::ST_CLEAR: n_state = (r_addr == 8'd255) ? tmpb_pkg::ST_IDLE
                                                             : tmpb_pkg::ST_CLEAR;
            default:            n_state = tmpb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmpb_pkg::ST_CLEAR;
            r_addr <= '0;
            r_busy_out <= 1'b0;
            r_rd_vld <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_lvl[c] <= tmpb_pkg::LvlW'(255);
                r_sum[c] <= '0;
            end
            r_req <= '0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) begin
                r_busy_out <= 1'b0;
            end
            unique case (r_state)
                tmpb_pkg::ST_IDLE: begin
                    r_req <= i_req;
                end
                tmpb_pkg::ST_READ: begin
                    for (int c = 0; c < 3; c++) begin
                        r_rd[c] <= r_hist[c][pix[c]];
                    end
                end
                tmpb_pkg::ST_WRITE: begin
                    for (int c = 0; c < 3; c++) begin
                        if (r_rd[c] != tmpb_pkg::BinMax) begin
                            r_hist[c][pix[c]] <= r_rd[c] + 1'b1;
                        end
                        r_sum[c] <= ({1'b0, r_sum[c]} + (tmpb_pkg::SumW+1)'(pix[c])
                                     > (tmpb_pkg::SumW+1)'(tmpb_pkg::SumMax))
                                    ? tmpb_pkg::SumMax : r_sum[c] + tmpb_pkg::SumW'(pix[c]);
                        r_acc[c] <= '0;
                        r_short[c] <= '0;
                        r_stop[c] <= 8'd255;
                    end
                    r_run <= '0;
                    r_rd_vld <= 1'b0;
                    r_addr <= 8'd255;
                end
                tmpb_pkg::ST_WALK: begin
                    // Read the bin at r_addr; add the previously read bin held in r_rd.
                    for (int c = 0; c < 3; c++) begin
                        r_rd[c] <= r_hist[c][r_addr];
                        if (r_rd_vld && r_acc[c] < walk_sum[c]) begin
                            r_short[c] <= walk_sum[c] - r_acc[c];
                            r_acc[c] <= r_acc[c] + walk_add[c];
                            r_run[c] <= 1'b1;
                            r_stop[c] <= r_rd_addr - 1'b1;
                        end
                    end
                    // Bin zero never adds to the total.
                    r_rd_addr <= r_addr;
                    r_rd_vld <= (r_addr != 8'd0);
                    r_addr <= r_addr - 1'b1;
                end
                tmpb_pkg::ST_FOLD: begin
                    for (int c = 0; c < 3; c++) begin
                        r_lvl[c] <= tmpb_pkg::LvlW'(stop_lvl[c]) + tmpb_pkg::LvlW'(i_offset);
                        r_sum[c] <= '0;
                    end
                    r_addr <= '0;
                end
                tmpb_pkg::ST_CLEAR: begin
                    for (int c = 0; c < 3; c++) begin
                        r_hist[c][r_addr] <= '0;
                    end
                    r_addr <= r_addr + 1'b1;
                end
                tmpb_pkg::ST_EMIT: begin
                    r_busy_out <= 1'b1;
                    r_out[0] <= (r_req.op == tmpb_pkg::OP_APPLY) ? tmpb_pkg::KIND_PIXEL
                                                                 : tmpb_pkg::KIND_LEVELS;
                    r_out[8:1] <= (r_req.op == tmpb_pkg::OP_APPLY &&
                                   {2'b0, r_req.red} > r_lvl[0]) ? tmpb_pkg::White : 8'd0;
                    r_out[16:9] <= (r_req.op == tmpb_pkg::OP_APPLY &&
                                    {2'b0, r_req.green} > r_lvl[1]) ? tmpb_pkg::White : 8'd0;
                    r_out[24:17] <= (r_req.op == tmpb_pkg::OP_APPLY &&
                                     {2'b0, r_req.blue} > r_lvl[2]) ? tmpb_pkg::White : 8'd0;
                    r_out[32:25] <= (r_req.op == tmpb_pkg::OP_APPLY) ? r_req.alpha : 8'd0;
                    r_out[41:33] <= r_lvl[0][8:0];
                    r_out[50:42] <= r_lvl[1][8:0];
                    r_out[59:51] <= r_lvl[2][8:0];
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- rtl/core/tile_mean_preserving_binarizer.sv -----
// Top level of the tile mean-preserving binarizer.
// A gather request (tuser 0) adds its pixel to the tile's per-channel histograms and
// sums; the gather marked with tlast closes the tile, walks the bins from 255 down to
// find each channel's threshold, adds the offset and returns one levels result. An
// apply request (tuser 1) returns the pixel binarized against the current levels. A
// request queue of QUEUE_DEPTH entries (two by default) parts the input from the back
// end, which takes requests from the queue's registered head. The back end takes a
// gather through accept, histogram read and write back, and an apply through accept
// and the result step; it takes a new request only from idle, with the output register
// free or draining. The tile-closing gather holds the back end for read and write back,
// a walk (one bin per cycle from a registered histogram read, all channels in
// parallel), a step to fold in step-back and offset, the result step and a histogram
// clear; its result is registered in the result step. One output register holds each
// result, and a result stalled there holds the back end while the queue still fills.
// After reset the back end clears every histogram bin before taking requests.
module tile_mean_preserving_binarizer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // red_in, green_in, blue_in, alpha_in
    input  logic [31:0] s_axis_tdata,
    // operation
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_out, green_out, blue_out, alpha_out, red_level, green_level, blue_level
    output logic [63:0] m_axis_tdata,
    // result_kind
    output logic        m_axis_tuser
);
    logic [7:0] r_offset;
    tmpb_pkg::t_req in_req, q_req;
    logic q_valid, q_ready;
    logic [59:0] res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    assign in_req.op    = tmpb_pkg::t_op'(s_axis_tuser);
    assign in_req.red   = s_axis_tdata[7:0];
    assign in_req.green = s_axis_tdata[15:8];
    assign in_req.blue  = s_axis_tdata[23:16];
    assign in_req.alpha = s_axis_tdata[31:24];
    assign in_req.last  = s_axis_tlast;

    tmpb_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    tmpb_back u_back (
        .i_clk, .i_rst_n, .i_offset(r_offset),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(res)
    );

    assign m_axis_tuser = res[0];
    assign m_axis_tdata = {5'd0, res[59:1]};
endmodule

// ----- rtl/core/tmpb_checker.sv -----
// Port-level checker for the binarizer, bound to the top level.
module tmpb_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("level result carries pixel data");
    a_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
        (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[7:0] == 8'd255))
        else $error("red not binary");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:59] == 5'd0)
        else $error("pad bits set");
endmodule

bind tile_mean_preserving_binarizer tmpb_port_checker u_chk (.*);

// ----- sim/tmpb_checker.sv -----
// Checker for the tile mean-preserving binarizer: predicts each result and compares it.
module tmpb_checker
    import tmpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);

    typedef struct {
        t_kind      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [8:0] red_lvl;
        logic [8:0] green_lvl;
        logic [8:0] blue_lvl;
    } t_result;

    t_result         results_due[$];
    logic [BinW-1:0] hist [3][256];
    logic [SumW-1:0] chan_sum [3];
    logic [LvlW-1:0] level [3];
    logic [7:0]      offset;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // Walk bins from the top until the white total covers the channel sum.
    function automatic logic [LvlW-1:0] bin_walk(input int ch);
        longint target;
        longint acc;
        longint shortfall;
        longint overshoot;
        int     lvl;
        bit     ran;
        target    = longint'(chan_sum[ch]);
        acc       = 0;
        shortfall = 0;
        overshoot = 0;
        lvl       = 255;
        ran       = 0;
        while (acc < target && lvl > 0) begin
            shortfall = target - acc;
            acc += longint'(hist[ch][lvl]) * 255;
            overshoot = acc - target;
            lvl--;
            ran = 1;
        end
        if (ran && overshoot > shortfall) lvl++;
        return LvlW'(lvl + offset);
    endfunction

    function automatic void add_pixel(input int ch, input logic [7:0] v);
        if (hist[ch][v] != BinMax) hist[ch][v] = hist[ch][v] + 1'b1;
        if ({1'b0, chan_sum[ch]} + v > {1'b0, SumMax}) chan_sum[ch] = SumMax;
        else chan_sum[ch] = chan_sum[ch] + v;
    endfunction

    function automatic logic [7:0] binarize(input logic [7:0] v, input int ch);
        return ({2'b00, v} > level[ch]) ? White : 8'd0;
    endfunction

    always @(posedge i_clk) begin
        t_op        op;
        logic [7:0] px [3];
        t_result    due;
        t_result    got;
        if (!i_rst_n) begin
            results_due.delete();
            for (int c = 0; c < 3; c++) begin
                for (int b = 0; b < 256; b++) hist[c][b] = '0;
                chan_sum[c] = '0;
                level[c]    = LvlW'(255);
            end
            offset = '0;
        end else begin
            if (i_cfg_we) offset = i_cfg_wdata;

            // Predict on each accepted request.
            if (s_axis_tvalid && s_axis_tready) begin
                op    = t_op'(s_axis_tuser);
                px[0] = s_axis_tdata[7:0];
                px[1] = s_axis_tdata[15:8];
                px[2] = s_axis_tdata[23:16];
                if (op == OP_GATHER) begin
                    for (int c = 0; c < 3; c++) add_pixel(c, px[c]);
                    if (s_axis_tlast) begin
                        for (int c = 0; c < 3; c++) level[c] = bin_walk(c);
                        for (int c = 0; c < 3; c++) begin
                            for (int b = 0; b < 256; b++) hist[c][b] = '0;
                            chan_sum[c] = '0;
                        end
                        due.kind  = KIND_LEVELS;
                        due.red   = '0;
                        due.green = '0;
                        due.blue  = '0;
                        due.alpha = '0;
                    end
                end else begin
                    due.kind  = KIND_PIXEL;
                    due.red   = binarize(px[0], 0);
                    due.green = binarize(px[1], 1);
                    due.blue  = binarize(px[2], 2);
                    due.alpha = s_axis_tdata[31:24];
                end
                if (op == OP_APPLY || s_axis_tlast) begin
                    due.red_lvl   = level[0][8:0];
                    due.green_lvl = level[1][8:0];
                    due.blue_lvl  = level[2][8:0];
                    results_due.push_back(due);
                end
            end

            // Compare each accepted result with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                got.kind      = t_kind'(m_axis_tuser);
                got.red       = m_axis_tdata[7:0];
                got.green     = m_axis_tdata[15:8];
                got.blue      = m_axis_tdata[23:16];
                got.alpha     = m_axis_tdata[31:24];
                got.red_lvl   = m_axis_tdata[40:32];
                got.green_lvl = m_axis_tdata[49:41];
                got.blue_lvl  = m_axis_tdata[58:50];
                if (results_due.size() == 0) begin
                    report("result with nothing predicted");
                end else begin
                    due = results_due.pop_front();
                    if (got.kind != due.kind)
                        report($sformatf("kind %0d, want %0d", got.kind, due.kind));
                    if (got.red != due.red)
                        report($sformatf("red_out %0d, want %0d", got.red, due.red));
                    if (got.green != due.green)
                        report($sformatf("green_out %0d, want %0d", got.green, due.green));
                    if (got.blue != due.blue)
                        report($sformatf("blue_out %0d, want %0d", got.blue, due.blue));
                    if (got.alpha != due.alpha)
                        report($sformatf("alpha_out %0d, want %0d", got.alpha, due.alpha));
                    if (got.red_lvl != due.red_lvl)
                        report($sformatf("red_level %0d, want %0d",
                                         got.red_lvl, due.red_lvl));
                    if (got.green_lvl != due.green_lvl)
                        report($sformatf("green_level %0d, want %0d",
                                         got.green_lvl, due.green_lvl));
                    if (got.blue_lvl != due.blue_lvl)
                        report($sformatf("blue_level %0d, want %0d",
                                         got.blue_lvl, due.blue_lvl));
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ----- sim/tb_tile_mean_preserving_binarizer.sv -----
// Testbench top: drives tiles of pixels and offsets, and gives the verdict.
module tb_tile_mean_preserving_binarizer;
    import tmpb_pkg::*;

    localparam int StallLimit  = 5000;  // cycles without any handshake
    localparam int DrainCycles = 700;   // covers a walk plus clear after the last request

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int pending;
    int results;
    int sent;
    int tiles;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    tile_mean_preserving_binarizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tmpb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Stall the result side at the rate of the current phase.
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("watchdog: no handshake for %0d cycles", StallLimit);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_px(input t_op op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {a, b, g, r};
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Wait for every result, let a walk in flight finish, then load the offset.
    task automatic set_offset(input logic [7:0] value);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // One tile: gathers ending with the end mark, then some applies.
    task automatic run_tile(input int n_gather, input int n_apply, input int tone);
        logic [7:0] base;
        base = 8'($urandom_range(255));
        for (int i = 0; i < n_gather; i++) begin
            if (tone != 0)
                send_px(OP_GATHER, base + 8'($urandom_range(40)), base - 8'($urandom_range(40)),
                        rand_chan(), rand_chan(), i == n_gather - 1);
            else
                send_px(OP_GATHER, rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                        i == n_gather - 1);
        end
        for (int i = 0; i < n_apply; i++)
            send_px(OP_APPLY, rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                    1'($urandom_range(1)));
        tiles++;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        sent          = 0;
        tiles         = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: applies before any tile end see the reset levels of 255.
        send_px(OP_APPLY, 8'd255, 8'd0, 8'd254, 8'd255, 1'b0);
        send_px(OP_APPLY, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
        // All-zero tile: empty walk on every channel.
        send_px(OP_GATHER, 8'd0, 8'd0, 8'd0, 8'd17, 1'b0);
        send_px(OP_GATHER, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_px(OP_APPLY, 8'd255, 8'd1, 8'd0, 8'd200, 1'b0);
        // Extreme tile: mixed full and empty pixels.
        send_px(OP_GATHER, 8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
        send_px(OP_GATHER, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
        send_px(OP_GATHER, 8'd255, 8'd255, 8'd0, 8'd99, 1'b0);
        send_px(OP_GATHER, 8'd1, 8'd0, 8'd128, 8'd1, 1'b1);
        send_px(OP_APPLY, 8'd255, 8'd254, 8'd128, 8'd77, 1'b0);
        send_px(OP_APPLY, 8'd1, 8'd0, 8'd129, 8'd255, 1'b0);
        // Low tile: walk runs down to the lowest bins.
        send_px(OP_GATHER, 8'd1, 8'd2, 8'd1, 8'd0, 1'b0);
        send_px(OP_GATHER, 8'd1, 8'd1, 8'd0, 8'd0, 1'b1);
        send_px(OP_APPLY, 8'd2, 8'd1, 8'd0, 8'd42, 1'b0);
        send_px(OP_APPLY, 8'd0, 8'd2, 8'd1, 8'd43, 1'b1);

        // Offset 255 on a small tile, then offset 0 again.
        set_offset(8'd255);
        run_tile(4, 3, 0);
        send_px(OP_APPLY, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        set_offset(8'd0);

        // Random tiles over idle/stall phases, new offset between phases.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            if (phase == 4) set_offset(8'd255);
            else if (phase != 0) set_offset(8'($urandom_range(255)));
            while (sent < 60 + (phase + 1) * 125) begin
                if ($urandom_range(9) == 0)
                    run_tile($urandom_range(60, 200), $urandom_range(2, 12),
                             $urandom_range(1));
                else
                    run_tile($urandom_range(1, 24), $urandom_range(2, 16),
                             $urandom_range(1));
            end
        end

        idle_pct      = 0;
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DrainCycles) @(posedge i_clk);
        $display("covered %0d requests in %0d tiles, %0d results checked",
                 sent, tiles, results);
        $display("offsets 0, 255 and random; idle and stall phases on both sides");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- tile_mean_preserving_binarizer.f -----
rtl/core/tmpb_pkg.sv
rtl/core/tmpb_front.sv
rtl/core/tmpb_back.sv
rtl/core/tile_mean_preserving_binarizer.sv
rtl/core/tmpb_checker.sv
sim/tmpb_checker.sv
sim/tb_tile_mean_preserving_binarizer.sv
